### hw/rtl/tepq_pkg.sv
// Shared types and constants for the timed event priority queue.
// No dependencies; every other file of the block refers to it by scoped names.
package tepq_pkg;

	localparam int ENTRIES   = 64;
	localparam int TICK_BITS = 32;
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	// removed-count tree: groups of eight kill bits, then one sum over the groups
	localparam int GRP   = 8;
	localparam int NGRP  = (ENTRIES + GRP - 1) / GRP;
	localparam int GRP_W = $clog2(GRP + 1);

	typedef enum logic [1:0] {
		FN_SCHED      = 2'd0,
		FN_CANCEL_ID  = 2'd1,
		FN_CANCEL_TAG = 2'd2,
		FN_POP        = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_LATE  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_POP,
		CMD_MARK_ID,
		CMD_MARK_TAG,
		CMD_COMPACT
	} cell_cmd_t;

	typedef struct packed {
		logic [15:0]          id;
		logic [15:0]          tag;
		logic [TICK_BITS-1:0] tick;
		logic [7:0]           prio;
	} slot_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_cmd_t cmd;
		slot_t     key;
	} cell_ctl_t;

endpackage

### hw/rtl/tepq_req_if.sv
// Request channel of the event queue: valid/ready plus one request item.
// Depends on tepq_pkg for the tick width.
interface tepq_req_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     func;
	logic [15:0]                    event_id;
	logic [15:0]                    name_tag;
	logic [tepq_pkg::TICK_BITS-1:0] due_tick;
	logic [7:0]                     prio;

	modport source (output valid, func, event_id, name_tag, due_tick, prio, input ready);
	modport sink   (input valid, func, event_id, name_tag, due_tick, prio, output ready);
endinterface

### hw/rtl/tepq_rsp_if.sv
// Response channel of the event queue: valid/ready plus one result item.
// Depends on tepq_pkg for the tick and count widths.
interface tepq_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [15:0]                    popped_id;
	logic [15:0]                    popped_tag;
	logic [tepq_pkg::TICK_BITS-1:0] popped_tick;
	logic [tepq_pkg::CNT_W-1:0]     removed_count;
	logic [tepq_pkg::TICK_BITS-1:0] now_tick;
	logic [tepq_pkg::CNT_W-1:0]     occupancy;

	modport source (output valid, status, popped_id, popped_tag, popped_tick,
		removed_count, now_tick, occupancy, input ready);
	modport sink   (input valid, status, popped_id, popped_tag, popped_tick,
		removed_count, now_tick, occupancy, output ready);
endinterface

### hw/rtl/timed_event_priority_queue.sv
// Timed event priority queue: a row of ENTRIES cells kept sorted by due tick,
// then higher priority, then newest first, with the head in cell 0.
// Depends on tepq_pkg, tepq_req_if, tepq_rsp_if and tepq_cell.
//
// Schedule and pop pass through S_EXEC, in which every cell compares against
// the key and shifts at once, then S_FIN, which posts the result. For cancel
// by id or by tag the matching cells are marked empty in S_EXEC, then in
// S_COMPACT the holes move one cell per cycle toward the tail by neighbor
// swaps until the row is packed, so how long this takes follows how far the
// live entries must travel. A result waits in an output register, and the
// next item is taken while it waits. Valid bits live in flip-flops cleared
// by reset, so there is no start-up pass.
module timed_event_priority_queue (
	input  logic clk,
	input  logic arst_n,
	tepq_req_if.sink   req,
	tepq_rsp_if.source rsp
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COMPACT, S_FIN} state_t;

	state_t                         state_q;
	tepq_pkg::func_t                func_q;
	tepq_pkg::slot_t                key_q;
	tepq_pkg::status_t              status_q;
	tepq_pkg::slot_t                pop_q;
	logic [tepq_pkg::CNT_W-1:0]     removed_q;
	logic [tepq_pkg::CNT_W-1:0]     count_q;
	logic [tepq_pkg::TICK_BITS-1:0] cur_tick_q;
	logic                           need_q;
	logic [tepq_pkg::ENTRIES-1:0]   kill_q;

	logic                           rsp_valid_q;
	tepq_pkg::status_t              out_status_q;
	tepq_pkg::slot_t                out_pop_q;
	logic [tepq_pkg::CNT_W-1:0]     out_removed_q;
	logic [tepq_pkg::TICK_BITS-1:0] out_now_q;
	logic [tepq_pkg::CNT_W-1:0]     out_count_q;

	logic [tepq_pkg::GRP_W-1:0]     grp_s1 [tepq_pkg::NGRP];

	tepq_pkg::cell_ctl_t            ctl;
	logic                           cell_v      [tepq_pkg::ENTRIES];
	tepq_pkg::slot_t                cell_d      [tepq_pkg::ENTRIES];
	logic                           cell_before [tepq_pkg::ENTRIES];
	logic                           cell_hit    [tepq_pkg::ENTRIES];
	logic [tepq_pkg::ENTRIES-1:0]   v_vec;
	logic [tepq_pkg::ENTRIES-1:0]   hit_vec;

	logic                                  out_free;
	logic                                  in_ready;
	logic                                  in_take;
	logic                                  late;
	logic                                  full;
	logic                                  sched_ok;
	logic                                  need;
	logic [tepq_pkg::CNT_W-1:0]            cnt_n;
	logic [tepq_pkg::TICK_BITS-1:0]        now_n;
	logic [tepq_pkg::NGRP*tepq_pkg::GRP-1:0] kill_pad;
	logic [tepq_pkg::GRP_W-1:0]            grp_cnt [tepq_pkg::NGRP];
	logic [tepq_pkg::CNT_W-1:0]            kill_sum;

	// ---------------- cell row ----------------
	for (genvar i = 0; i < tepq_pkg::ENTRIES; i++) begin : g_cell
		logic            lv;
		tepq_pkg::slot_t ld;
		logic            lb;
		logic            rv;
		tepq_pkg::slot_t rd;

		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign ld = '0;
			assign lb = 1'b1;
		end else begin : g_mid
			assign lv = cell_v[i-1];
			assign ld = cell_d[i-1];
			assign lb = cell_before[i-1];
		end
		if (i == tepq_pkg::ENTRIES - 1) begin : g_tail
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_body
			assign rv = cell_v[i+1];
			assign rd = cell_d[i+1];
		end

		tepq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_valid  (lv),
			.left_data   (ld),
			.left_before (lb),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (cell_v[i]),
			.data        (cell_d[i]),
			.ahead       (cell_before[i]),
			.hit         (cell_hit[i])
		);

		assign v_vec[i]   = cell_v[i];
		assign hit_vec[i] = cell_hit[i];
	end

	// a hole with a live entry to its right means the row is not packed yet
	assign need = |(~v_vec[tepq_pkg::ENTRIES-2:0] & v_vec[tepq_pkg::ENTRIES-1:1]);

	// ---------------- control ----------------
	assign out_free = !rsp_valid_q || rsp.ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_FIN) && out_free);
	assign in_take  = req.valid && in_ready;

	assign late     = key_q.tick < cur_tick_q;
	assign full     = count_q == tepq_pkg::CNT_W'(tepq_pkg::ENTRIES);
	assign sched_ok = (func_q == tepq_pkg::FN_SCHED) && !late && !full;

	always_comb begin
		ctl.key = key_q;
		ctl.cmd = tepq_pkg::CMD_HOLD;
		if (state_q == S_EXEC) begin
			case (func_q)
				tepq_pkg::FN_SCHED: begin
					if (sched_ok) begin
						ctl.cmd = tepq_pkg::CMD_INSERT;
					end
				end
				tepq_pkg::FN_CANCEL_ID:  ctl.cmd = tepq_pkg::CMD_MARK_ID;
				tepq_pkg::FN_CANCEL_TAG: ctl.cmd = tepq_pkg::CMD_MARK_TAG;
				tepq_pkg::FN_POP: begin
					if (count_q != '0) begin
						ctl.cmd = tepq_pkg::CMD_POP;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_COMPACT) begin
			ctl.cmd = tepq_pkg::CMD_COMPACT;
		end
	end

	assign cnt_n = count_q + tepq_pkg::CNT_W'(sched_ok) - removed_q;
	assign now_n = (cnt_n != '0) ? cell_d[0].tick : cur_tick_q;

	// ---------------- removed-count tree ----------------
	assign kill_pad = (tepq_pkg::NGRP * tepq_pkg::GRP)'(kill_q);

	always_comb begin
		for (int g = 0; g < tepq_pkg::NGRP; g++) begin
			grp_cnt[g] = '0;
			for (int b = 0; b < tepq_pkg::GRP; b++) begin
				grp_cnt[g] = grp_cnt[g] + tepq_pkg::GRP_W'(kill_pad[g*tepq_pkg::GRP + b]);
			end
		end
	end

	always_comb begin
		kill_sum = '0;
		for (int g = 0; g < tepq_pkg::NGRP; g++) begin
			kill_sum = kill_sum + tepq_pkg::CNT_W'(grp_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_cnt;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			cur_tick_q  <= '0;
			need_q      <= 1'b0;
		end else begin
			rsp_valid_q <= ((state_q == S_FIN) && out_free) || (rsp_valid_q && !rsp.ready);
			if (in_take) begin
				func_q        <= tepq_pkg::func_t'(req.func);
				key_q.id      <= req.event_id;
				key_q.tag     <= req.name_tag;
				key_q.tick    <= req.due_tick;
				key_q.prio    <= req.prio;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q  <= tepq_pkg::ST_OK;
					pop_q     <= '0;
					removed_q <= '0;
					kill_q    <= hit_vec;
					need_q    <= 1'b1;
					case (func_q)
						tepq_pkg::FN_SCHED: begin
							if (late) begin
								status_q <= tepq_pkg::ST_LATE;
							end else if (full) begin
								status_q <= tepq_pkg::ST_FULL;
							end
						end
						tepq_pkg::FN_POP: begin
							if (count_q == '0) begin
								status_q <= tepq_pkg::ST_EMPTY;
							end else begin
								pop_q     <= cell_d[0];
								removed_q <= tepq_pkg::CNT_W'(1);
							end
						end
						default: begin
						end
					endcase
					if ((func_q == tepq_pkg::FN_CANCEL_ID) ||
						(func_q == tepq_pkg::FN_CANCEL_TAG)) begin
						state_q <= S_COMPACT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_COMPACT: begin
					// need_q low: the row did not change in the last swap step
					need_q    <= need;
					removed_q <= kill_sum;
					if (!need_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_status_q  <= status_q;
						out_pop_q     <= pop_q;
						out_removed_q <= removed_q;
						out_now_q     <= now_n;
						out_count_q   <= cnt_n;
						count_q       <= cnt_n;
						cur_tick_q    <= now_n;
						state_q       <= in_take ? S_EXEC : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready         = in_ready;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.popped_id     = out_pop_q.id;
	assign rsp.popped_tag    = out_pop_q.tag;
	assign rsp.popped_tick   = out_pop_q.tick;
	assign rsp.removed_count = out_removed_q;
	assign rsp.now_tick      = out_now_q;
	assign rsp.occupancy     = out_count_q;

	// ---------------- checks ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tepq_pkg::CNT_W'(tepq_pkg::ENTRIES))
		else $error("occupancy above capacity");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cell_v[0] == (count_q != '0)))
		else $error("head valid bit disagrees with occupancy");

	a_packed_stable: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_COMPACT) && !need_q) |-> !need)
		else $error("row left compaction unpacked");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && (count_q >= tepq_pkg::CNT_W'(2))) |->
		(cell_d[0].tick <= cell_d[1].tick))
		else $error("head entries out of tick order");

endmodule

### hw/rtl/tepq_cell.sv
// One slot of the sorted event row; among the cells it talks only to its two neighbors.
// Depends on tepq_pkg for the slot and command types.
module tepq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tepq_pkg::cell_ctl_t ctl,
	input  logic                left_valid,
	input  tepq_pkg::slot_t     left_data,
	input  logic                left_before,
	input  logic                right_valid,
	input  tepq_pkg::slot_t     right_data,
	output logic                valid,
	output tepq_pkg::slot_t     data,
	output logic                ahead,
	output logic                hit
);

	logic            valid_q;
	tepq_pkg::slot_t data_q;
	logic            valid_d;
	tepq_pkg::slot_t data_d;

	// this entry is served ahead of the key being inserted
	assign ahead = valid_q && ((data_q.tick < ctl.key.tick) ||
		((data_q.tick == ctl.key.tick) && (data_q.prio > ctl.key.prio)));

	always_comb begin
		hit = 1'b0;
		if (ctl.cmd == tepq_pkg::CMD_MARK_ID) begin
			hit = valid_q && (data_q.id == ctl.key.id);
		end else if (ctl.cmd == tepq_pkg::CMD_MARK_TAG) begin
			hit = valid_q && (data_q.tag == ctl.key.tag);
		end
	end

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		case (ctl.cmd)
			tepq_pkg::CMD_INSERT: begin
				if (!ahead) begin
					if (left_before) begin
						valid_d = 1'b1;
						data_d  = ctl.key;
					end else begin
						valid_d = left_valid;
						data_d  = left_data;
					end
				end
			end
			tepq_pkg::CMD_POP: begin
				valid_d = right_valid;
				data_d  = right_data;
			end
			tepq_pkg::CMD_MARK_ID, tepq_pkg::CMD_MARK_TAG: begin
				if (hit) begin
					valid_d = 1'b0;
				end
			end
			tepq_pkg::CMD_COMPACT: begin
				// a hole swaps with a live right neighbor; the pairs never overlap
				if (!valid_q && right_valid) begin
					valid_d = 1'b1;
					data_d  = right_data;
				end else if (valid_q && !left_valid) begin
					valid_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule
